// ===== src/modexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

   // Default word width of base, exponent, modulus and result.
   localparam int WORD_BITS_DEFAULT = 32;

   // Modulus held by the key register after reset.
   localparam longint unsigned MODULUS_RESET = 2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/modular_exponentiation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_base_value, req_exponent
// rsp       out        rsp_valid/rsp_stall  rsp_power_result
// csr       in         csr_write_enable     csr_write_data (modulus)
//
// Each item first reduces the base, then for every exponent bit, most significant first,
// squares the running value and multiplies it by the base where the bit is set; a zero
// modulus skips all of this and answers with zero.
// The single shift-add-reduce unit does every step, one multiplier bit per cycle.
// Reset is synchronous and active high; it returns the modulus to 2 and drops rsp_valid.
// A stalled result waits in the output register while the next item is taken and worked.

module modular_exponentiation #(
   parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [WORD_BITS-1:0] req_base_value,
   input  wire logic [WORD_BITS-1:0] req_exponent,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [WORD_BITS-1:0]      rsp_power_result,
   input  wire logic                 csr_write_enable,
   input  wire logic [WORD_BITS-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(WORD_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_BITS - 1);

   modexp_pkg::state_type state_ff, state_in;

   logic [WORD_BITS-1:0] mod_ff;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS-1:0] mplr_ff, mplr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     ebit_ff, ebit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 step_last;
   logic                 ebit_last;
   logic [WORD_BITS-1:0] addend_sel;
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS+1:0] unit_sum;
   logic [WORD_BITS+2:0] unit_sub1;
   logic [WORD_BITS+2:0] unit_sub2;
   logic [WORD_BITS-1:0] unit_out;

   assign req_stall        = (state_ff != modexp_pkg::ST_IDLE);
   assign req_xfer         = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign step_last        = (cnt_ff == LAST_STEP);
   assign ebit_last        = (ebit_ff == LAST_STEP);

   // Shared unit: 2 * prod + addend, reduced once or twice by the modulus.
   // The running value stays below the modulus and the addend never exceeds it, so the
   // sum stays below three times the modulus.
   always_comb begin
      unique case (state_ff)
         modexp_pkg::ST_REDUCE: addend_sel = WORD_BITS'(1);
         modexp_pkg::ST_SQUARE: addend_sel = acc_ff;
         default:               addend_sel = base_ff;
      endcase
      addend    = mplr_ff[WORD_BITS-1] ? addend_sel : '0;
      unit_sum  = {1'b0, prod_ff, 1'b0} + {2'b00, addend};
      unit_sub1 = {1'b0, unit_sum} - {3'b000, mod_ff};
      unit_sub2 = {1'b0, unit_sum} - {2'b00, mod_ff, 1'b0};
      priority if (!unit_sub2[WORD_BITS+2]) begin
         unit_out = unit_sub2[WORD_BITS-1:0];
      end else if (!unit_sub1[WORD_BITS+2]) begin
         unit_out = unit_sub1[WORD_BITS-1:0];
      end else begin
         unit_out = unit_sum[WORD_BITS-1:0];
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (mod_ff == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (step_last) begin
               state_in = modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            if (step_last) begin
               priority if (exp_ff[WORD_BITS-1]) begin
                  state_in = modexp_pkg::ST_MULT;
               end else if (ebit_last) begin
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  state_in = modexp_pkg::ST_SQUARE;
               end
            end
         end
         modexp_pkg::ST_MULT: begin
            if (step_last) begin
               state_in = ebit_last ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = modexp_pkg::ST_IDLE;
            end
         end
         default: state_in = modexp_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates driven by the sequencer.
   always_comb begin
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mplr_in      = mplr_ff;
      cnt_in       = cnt_ff;
      ebit_in      = ebit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_xfer) begin
               exp_in  = req_exponent;
               mplr_in = req_base_value;
               prod_in = '0;
               cnt_in  = '0;
               ebit_in = '0;
               // The empty product is 1, or 0 when everything reduces to zero.
               acc_in  = (mod_ff <= WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            end
         end
         modexp_pkg::ST_REDUCE: begin
            prod_in = unit_out;
            mplr_in = {mplr_ff[WORD_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (step_last) begin
               base_in = unit_out;
               prod_in = '0;
               mplr_in = acc_ff;
               cnt_in  = '0;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            prod_in = unit_out;
            mplr_in = {mplr_ff[WORD_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (step_last) begin
               acc_in  = unit_out;
               prod_in = '0;
               mplr_in = unit_out;
               cnt_in  = '0;
               // A clear exponent bit skips the multiplication.
               if (!exp_ff[WORD_BITS-1]) begin
                  exp_in  = {exp_ff[WORD_BITS-2:0], 1'b0};
                  ebit_in = ebit_ff + 1'b1;
               end
            end
         end
         modexp_pkg::ST_MULT: begin
            prod_in = unit_out;
            mplr_in = {mplr_ff[WORD_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (step_last) begin
               acc_in  = unit_out;
               prod_in = '0;
               mplr_in = unit_out;
               cnt_in  = '0;
               exp_in  = {exp_ff[WORD_BITS-2:0], 1'b0};
               ebit_in = ebit_ff + 1'b1;
            end
         end
         modexp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers and the key register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= WORD_BITS'(modexp_pkg::MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            mod_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      mplr_ff     <= mplr_in;
      cnt_ff      <= cnt_in;
      ebit_ff     <= ebit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A finished item always lands in the output register.
   a_done_presents: assert property (@(posedge clock) disable iff (reset)
      (state_ff == modexp_pkg::ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

   // An accepted item starts the base reduction, or finishes at once for a zero modulus.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == modexp_pkg::ST_REDUCE || state_ff == modexp_pkg::ST_DONE))
      else $error("accepted item did not start the sequencer");

   // A pass of the shared unit entered from another state starts at its first multiplier bit.
   a_pass_aligned: assert property (@(posedge clock) disable iff (reset)
      (!$stable(state_ff) && (state_ff == modexp_pkg::ST_REDUCE
         || state_ff == modexp_pkg::ST_SQUARE || state_ff == modexp_pkg::ST_MULT))
      |-> (cnt_ff == '0))
      else $error("pass started with a nonzero step count");

endmodule

`default_nettype wire

// ===== dv/modexp_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and key register ports of the modular exponentiation
// block. It predicts base^exponent mod n for every request transfer and compares each
// response transfer with the oldest prediction still waiting.
module modexp_checker #(
   parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_base_value,
   input  logic [WORD_BITS-1:0] req_exponent,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [WORD_BITS-1:0] rsp_power_result,
   input  logic                 csr_write_enable,
   input  logic [WORD_BITS-1:0] csr_write_data,
   output int                   pending_count,
   output int                   error_count
);

   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [2*WORD_BITS-1:0] wide_type;

   // One outstanding power with the operands that produced it.
   typedef struct packed {
      word_type base_value;
      word_type exponent;
      word_type modulus;
      word_type power_result;
   } power_entry_type;

   power_entry_type expected_powers[$];
   word_type        modulus_shadow;

   initial begin
      pending_count  = 0;
      error_count    = 0;
      modulus_shadow = word_type'(modexp_pkg::MODULUS_RESET);
   end

   // Square-and-multiply over the exponent bits, most significant first. Products are
   // taken at double width, so every reduction is exact for any 32-bit modulus.
   function automatic word_type modular_power(input word_type base_in,
                                              input word_type exponent_in,
                                              input word_type modulus_in);
      wide_type m;
      wide_type b;
      wide_type acc;
      int       i;
      // A zero modulus has no meaning; the block answers with zero.
      if (modulus_in == '0) return '0;
      m   = wide_type'(modulus_in);
      b   = wide_type'(base_in) % m;
      // With a modulus of one this starts at zero, so even a zero exponent gives zero.
      acc = wide_type'(1) % m;
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (exponent_in[i]) acc = (acc * b) % m;
      end
      return word_type'(acc);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] modexp mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin : watch_channels
      power_entry_type head;
      power_entry_type entry;
      if (reset) begin
         expected_powers.delete();
         modulus_shadow = word_type'(modexp_pkg::MODULUS_RESET);
         pending_count <= 0;
      end else begin
         // A response transfer belongs to the oldest request still outstanding.
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding",
                                         rsp_power_result));
            end else begin
               head = expected_powers.pop_front();
               if (rsp_power_result !== head.power_result)
                  report_mismatch($sformatf("%h^%h mod %h gave %h, predicted %h",
                                            head.base_value, head.exponent, head.modulus,
                                            rsp_power_result, head.power_result));
            end
         end

         // A request transfer uses the modulus in force at that edge.
         if (req_valid && !req_stall) begin
            entry.base_value   = req_base_value;
            entry.exponent     = req_exponent;
            entry.modulus      = modulus_shadow;
            entry.power_result = modular_power(req_base_value, req_exponent, modulus_shadow);
            expected_powers.push_back(entry);
         end

         // The key register takes effect for requests after this edge.
         if (csr_write_enable) modulus_shadow = csr_write_data;

         pending_count <= expected_powers.size();
      end
   end

endmodule

// ===== dv/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;

   localparam int WORD_BITS        = modexp_pkg::WORD_BITS_DEFAULT;
   localparam int RESET_CYCLES     = 4;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 34;
   localparam int PRESSURE_PHASE   = 4;
   localparam int LONG_HOLD_CYCLES = 10000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int TAIL_CYCLES      = 3200;
   localparam int CYCLE_LIMIT      = 5000000;
   localparam int HEAVY_IDLE_PCT   = 84;
   localparam int LIGHT_IDLE_PCT   = 20;
   localparam int RSA_MODULUS      = 3233;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   word_type      req_base_value   = '0;
   word_type      req_exponent     = '0;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   word_type      rsp_power_result;
   logic          csr_write_enable = 1'b0;
   word_type      csr_write_data   = '0;

   idle_mode_type idle_mode        = IDLE_NONE;
   logic          hold_request     = 1'b0;
   logic          hold_done        = 1'b0;
   int            hold_count       = 0;
   int            cycle_count      = 0;
   word_type      modulus_setting  = word_type'(modexp_pkg::MODULUS_RESET);
   int            pending_count;
   int            error_count;

   always #5 clock = ~clock;

   modular_exponentiation #(
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_base_value  (req_base_value),
      .req_exponent    (req_exponent),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_power_result(rsp_power_result),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   modexp_checker #(
      .WORD_BITS(WORD_BITS)
   ) power_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_base_value  (req_base_value),
      .req_exponent    (req_exponent),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_power_result(rsp_power_result),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .pending_count   (pending_count),
      .error_count     (error_count)
   );

   // Response side: one long hold-off when asked for, otherwise random stalls by mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == LONG_HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_stall <= ($urandom_range(0, 99) < HEAVY_IDLE_PCT);
            IDLE_BOTH:     rsp_stall <= ($urandom_range(0, 99) < LIGHT_IDLE_PCT);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one request, with random idle cycles first, and returns at its transfer.
   // Valid stays high into the next request when no idle cycle falls between them.
   task automatic send_item(input word_type base_value, input word_type exponent);
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SENDER) ? HEAVY_IDLE_PCT :
                 (idle_mode == IDLE_BOTH)   ? LIGHT_IDLE_PCT : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_base_value <= base_value;
      req_exponent   <= exponent;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted power has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The key register is only written while the block is idle.
   task automatic write_modulus(input word_type value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      modulus_setting = value;
   endtask

   initial begin : stimulus
      int       phase;
      int       item;
      word_type base_value;
      word_type exponent;
      word_type modulus_value;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Modulus of two straight out of reset, before any write.
      send_item('0, '0);
      send_item('1, '1);
      send_item(word_type'(3), word_type'(1));

      // Small RSA-sized key: zero exponent, base equal to and just below the modulus,
      // zero base, full-scale operands and a lone top exponent bit.
      write_modulus(word_type'(RSA_MODULUS));
      send_item(word_type'(65), word_type'(17));
      send_item('0, '0);
      send_item('0, word_type'(5));
      send_item(word_type'(RSA_MODULUS), word_type'(7));
      send_item(word_type'(RSA_MODULUS - 1), word_type'(2));
      send_item('1, '1);
      send_item(word_type'(1), '1);
      send_item(word_type'(2), word_type'(1) << (WORD_BITS - 1));
      send_item(word_type'(123), word_type'(1));

      // Largest modulus: products need the full double width.
      write_modulus('1);
      send_item('1, word_type'(3));
      send_item('1 - word_type'(1), '1);
      send_item(word_type'(1) << (WORD_BITS - 1), word_type'(2));
      send_item(word_type'(5), '0);

      // Modulus of one reduces everything to zero, even a zero exponent.
      write_modulus(word_type'(1));
      send_item(word_type'(7), '0);
      send_item('1, '1);

      // A zero modulus answers with zero.
      write_modulus('0);
      send_item(word_type'(9), word_type'(3));
      send_item('0, '0);

      // Smallest meaningful modulus, written explicitly.
      write_modulus(word_type'(2));
      send_item(word_type'(5), '1);

      // Random phases, each with its own key and idle pattern.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            modulus_value = '1;
         end else if (phase == 1) begin
            modulus_value = word_type'(2);
         end else begin
            case ($urandom_range(0, 5))
               0:       modulus_value = word_type'($urandom_range(2, 255));
               1:       modulus_value = word_type'($urandom_range(2, 65535));
               2, 3:    modulus_value = word_type'($urandom())
                                        | (word_type'(1) << (WORD_BITS - 1));
               4:       modulus_value = '1 - word_type'($urandom_range(0, 8));
               default: modulus_value = word_type'($urandom()) | word_type'(2);
            endcase
         end
         write_modulus(modulus_value);
         idle_mode <= idle_mode_type'(phase % 4);

         // In the pressure phase the receiver holds off long enough for the block
         // to fill and stall its input while requests keep being offered.
         if (phase == PRESSURE_PHASE) hold_request <= 1'b1;

         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            case ($urandom_range(0, 7))
               0:       base_value = '0;
               1:       base_value = '1;
               2:       base_value = modulus_setting;
               3:       base_value = modulus_setting - word_type'(1);
               4:       base_value = modulus_setting + word_type'($urandom_range(1, 1000));
               default: base_value = word_type'($urandom());
            endcase
            case ($urandom_range(0, 7))
               0:       exponent = '0;
               1:       exponent = '1;
               2:       exponent = word_type'(1) << $urandom_range(0, WORD_BITS - 1);
               3:       exponent = word_type'($urandom_range(0, 15));
               default: exponent = word_type'($urandom());
            endcase
            send_item(base_value, exponent);
         end

         // The sender pauses here until every outstanding power has come back.
         drain_results();
         hold_request <= 1'b0;
      end

      // Give a stray response time to show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/modexp_pkg.sv
src/modular_exponentiation.sv
dv/modexp_checker.sv
dv/modular_exponentiation_tb.sv
